[rtl/fbd_pkg.sv]
// ----------------------------------------------------------------------------
// fbd_pkg
// Shared widths, constants, state codes and inter-module structs for the
// fractional baud divider search block.
// ----------------------------------------------------------------------------
package fbd_pkg;

    localparam int CLK_W      = 27;   // uart_clock_hz
    localparam int BAUD_W     = 22;   // baud_rate
    localparam int DIV_OUT_W  = 16;   // divisor field
    localparam int MUL_W      = 4;    // mul_value / add_value fields
    localparam int ERR_W      = 32;   // error_hz field
    localparam int PCT_W      = 7;    // max_error_percent register
    localparam int RATE_SHIFT = 4;    // the fixed 16x oversampling

    localparam int DIVISOR_BITS_DEF = 16;

    localparam logic [MUL_W-1:0] MUL_FIRST = 4'd1;
    localparam logic [MUL_W-1:0] MUL_LAST  = 4'd15;
    localparam logic [PCT_W-1:0] MAX_ERR_RESET = 7'd3;
    localparam logic [ERR_W-1:0] NO_ERR = 32'hFFFF_FFFF;
    localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

    // shared divider operand widths
    localparam int DVD_NUM_W = CLK_W + MUL_W - RATE_SHIFT;
    localparam int DVD_DEN_W = BAUD_W;

    typedef struct packed {
        logic                 start;
        logic [DVD_NUM_W-1:0] num;
        logic [DVD_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DVD_NUM_W-1:0] quot;
    } t_div_rsp;

    typedef struct packed {
        logic [DIV_OUT_W-1:0] divisor;
        logic [MUL_W-1:0]     mul_value;
        logic [MUL_W-1:0]     add_value;
        logic [ERR_W-1:0]     error_hz;
        logic                 setting_ok;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NOM_START,
        S_NOM_WAIT,
        S_D_INIT,
        S_PREP,
        S_CAND_START,
        S_CAND_WAIT,
        S_CHECK_MUL,
        S_CHECK_CMP,
        S_FINISH
    } t_state;

endpackage

[rtl/fbd_divider.sv]
// ----------------------------------------------------------------------------
// fbd_divider
// Restoring unsigned divider, one quotient bit per cycle, shared by the
// nominal divisor step and every candidate rate.
// ----------------------------------------------------------------------------
module fbd_divider
    import fbd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(DVD_NUM_W + 1);

    logic [DVD_NUM_W-1:0] r_quot, n_quot;
    logic [DVD_DEN_W-1:0] r_rem, n_rem;
    logic [DVD_DEN_W-1:0] r_den, n_den;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_busy, n_busy;
    logic                 r_done, n_done;

    logic [DVD_DEN_W:0]   rem_shift;
    logic [DVD_DEN_W:0]   rem_sub;
    logic                 q_bit;

    always_comb begin
        rem_shift = {r_rem, r_quot[DVD_NUM_W-1]};
        rem_sub   = rem_shift - {1'b0, r_den};
        q_bit     = (rem_shift >= {1'b0, r_den});

        n_quot = r_quot;
        n_rem  = r_rem;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;

        if (r_busy) begin
            n_quot = {r_quot[DVD_NUM_W-2:0], q_bit};
            // remainder stays below the divisor, so its top bit is always clear
            n_rem  = q_bit ? rem_sub[DVD_DEN_W-1:0] : rem_shift[DVD_DEN_W-1:0];
            n_cnt  = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (i_req.start) begin
            n_quot = i_req.num;
            n_rem  = '0;
            n_den  = i_req.den;
            n_cnt  = CNT_W'(DVD_NUM_W);
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_den  <= n_den;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

[rtl/fbd_search.sv]
// ----------------------------------------------------------------------------
// fbd_search
// Sequencer that walks divisor, multiplier and add value, drives the shared
// divider for each candidate, keeps the best one and holds the result item.
// ----------------------------------------------------------------------------
module fbd_search
    import fbd_pkg::*;
#(
    parameter int DIVISOR_BITS = DIVISOR_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [CLK_W-1:0]  i_clk_hz,
    input  logic [BAUD_W-1:0] i_baud,
    input  logic [PCT_W-1:0]  i_max_err,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_result           o_result,
    output t_div_req          o_div_req,
    input  t_div_rsp          i_div_rsp
);

    localparam int DB     = DIVISOR_BITS;
    localparam int SUM_W  = MUL_W + 1;
    localparam int PDEN_W = DB + SUM_W;
    localparam int PNUM_W = CLK_W + MUL_W;
    localparam int PE_W   = ERR_W + PCT_W;
    localparam int PL_W   = PCT_W + 1 + BAUD_W;
    localparam logic [DVD_NUM_W-1:0] DIV_MAX_W = DVD_NUM_W'((1 << DB) - 1);

    t_state              r_state, n_state;
    logic [CLK_W-1:0]    r_clk_hz, n_clk_hz;
    logic [BAUD_W-1:0]   r_baud, n_baud;
    logic [DB-1:0]       r_d_cur, n_d_cur;
    logic [DB-1:0]       r_d_hi, n_d_hi;
    logic [MUL_W-1:0]    r_m, n_m;
    logic [MUL_W-1:0]    r_a, n_a;
    logic [DVD_NUM_W-1:0] r_num, n_num;
    logic [DVD_DEN_W-1:0] r_den, n_den;
    logic [DB-1:0]       r_best_div, n_best_div;
    logic [MUL_W-1:0]    r_best_mul, n_best_mul;
    logic [MUL_W-1:0]    r_best_add, n_best_add;
    logic [ERR_W-1:0]    r_best_err, n_best_err;
    logic                r_found, n_found;
    logic                r_ok, n_ok;
    logic [PE_W-1:0]     r_prod_e, n_prod_e;
    logic [PL_W-1:0]     r_prod_l, n_prod_l;
    logic                r_out_valid, n_out_valid;
    t_result             r_out, n_out;

    logic [SUM_W-1:0]     sum_ma;
    logic [PNUM_W-1:0]    prod_num;
    logic [PDEN_W-1:0]    prod_den;
    logic [DVD_NUM_W-1:0] quot;
    logic [DVD_NUM_W-1:0] baud_ext;
    logic [DVD_NUM_W-1:0] cand_err;
    logic [DB-1:0]        nominal;
    logic                 div_start;

    always_comb begin
        sum_ma   = {1'b0, r_m} + {1'b0, r_a};
        prod_num = PNUM_W'(r_clk_hz) * PNUM_W'(r_m);
        prod_den = PDEN_W'(r_d_cur) * PDEN_W'(sum_ma);
        quot     = i_div_rsp.quot;
        baud_ext = DVD_NUM_W'(r_baud);
        cand_err = (quot > baud_ext) ? (quot - baud_ext) : (baud_ext - quot);
        nominal  = (quot > DIV_MAX_W) ? DIV_MAX_W[DB-1:0] : quot[DB-1:0];

        n_state     = r_state;
        n_clk_hz    = r_clk_hz;
        n_baud      = r_baud;
        n_d_cur     = r_d_cur;
        n_d_hi      = r_d_hi;
        n_m         = r_m;
        n_a         = r_a;
        n_num       = r_num;
        n_den       = r_den;
        n_best_div  = r_best_div;
        n_best_mul  = r_best_mul;
        n_best_add  = r_best_add;
        n_best_err  = r_best_err;
        n_found     = r_found;
        n_ok        = r_ok;
        n_prod_e    = r_prod_e;
        n_prod_l    = r_prod_l;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        div_start   = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_clk_hz   = i_clk_hz;
                    n_baud     = i_baud;
                    n_best_div = '0;
                    n_best_mul = MUL_FIRST;
                    n_best_add = '0;
                    n_best_err = NO_ERR;
                    n_found    = 1'b0;
                    n_ok       = 1'b0;
                    n_state    = (i_baud == '0) ? S_FINISH : S_NOM_START;
                end
            end
            S_NOM_START: begin
                // clk / (16 * baud) == (clk >> 4) / baud
                div_start = 1'b1;
                n_num     = DVD_NUM_W'(r_clk_hz >> RATE_SHIFT);
                n_den     = r_baud;
                n_state   = S_NOM_WAIT;
            end
            S_NOM_WAIT: begin
                if (i_div_rsp.done) begin
                    n_d_hi  = nominal;
                    n_d_cur = nominal >> 1;
                    n_state = S_D_INIT;
                end
            end
            S_D_INIT: begin
                n_m = MUL_FIRST;
                n_a = '0;
                if (r_d_cur > r_d_hi) begin
                    n_state = S_CHECK_MUL;
                end else if (r_d_cur == '0) begin
                    // divisor zero is skipped
                    n_d_cur = DB'(1);
                end else begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_num   = prod_num[PNUM_W-1:RATE_SHIFT];
                n_den   = DVD_DEN_W'(prod_den);
                n_state = S_CAND_START;
            end
            S_CAND_START: begin
                div_start = 1'b1;
                n_state   = S_CAND_WAIT;
            end
            S_CAND_WAIT: begin
                if (i_div_rsp.done) begin
                    if (ERR_W'(cand_err) < r_best_err) begin
                        n_best_err = ERR_W'(cand_err);
                        n_best_div = r_d_cur;
                        n_best_mul = r_m;
                        n_best_add = r_a;
                        n_found    = 1'b1;
                    end
                    n_state = S_PREP;
                    if ((r_a + MUL_W'(1)) < r_m) begin
                        n_a = r_a + MUL_W'(1);
                    end else if (r_m < MUL_LAST) begin
                        n_m = r_m + MUL_W'(1);
                        n_a = '0;
                    end else if (r_d_cur < r_d_hi) begin
                        n_d_cur = r_d_cur + DB'(1);
                        n_m     = MUL_FIRST;
                        n_a     = '0;
                    end else begin
                        n_state = S_CHECK_MUL;
                    end
                end
            end
            S_CHECK_MUL: begin
                // floor(err*100/baud) <= limit  <=>  err*100 < (limit+1)*baud
                n_prod_e = PE_W'(r_best_err) * PE_W'(PCT_SCALE);
                n_prod_l = PL_W'({1'b0, i_max_err} + (PCT_W + 1)'(1)) * PL_W'(r_baud);
                n_state  = r_found ? S_CHECK_CMP : S_FINISH;
            end
            S_CHECK_CMP: begin
                n_ok    = (r_prod_e < PE_W'(r_prod_l));
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid       = 1'b1;
                    n_out.divisor     = DIV_OUT_W'(r_best_div);
                    n_out.mul_value   = r_best_mul;
                    n_out.add_value   = r_best_add;
                    n_out.error_hz    = r_best_err;
                    n_out.setting_ok  = r_ok;
                    n_state           = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_clk_hz   <= n_clk_hz;
        r_baud     <= n_baud;
        r_d_cur    <= n_d_cur;
        r_d_hi     <= n_d_hi;
        r_m        <= n_m;
        r_a        <= n_a;
        r_num      <= n_num;
        r_den      <= n_den;
        r_best_div <= n_best_div;
        r_best_mul <= n_best_mul;
        r_best_add <= n_best_add;
        r_best_err <= n_best_err;
        r_found    <= n_found;
        r_ok       <= n_ok;
        r_prod_e   <= n_prod_e;
        r_prod_l   <= n_prod_l;
        r_out      <= n_out;
    end

    // operands are taken by the divider at the edge after the start cycle's update
    assign o_div_req.start = div_start;
    assign o_div_req.num   = n_num;
    assign o_div_req.den   = n_den;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

[rtl/fractional_baud_divider_search_top.sv]
// ----------------------------------------------------------------------------
// fractional_baud_divider_search_top
// UART fractional baud setting search: divisor, MulVal and DivAddVal with
// the smallest rate error, plus an error-limit check.
// ----------------------------------------------------------------------------
// One request is worked at a time. After the item is taken the nominal
// divisor D = clk / (16 * baud) is found with the shared restoring
// divider, then every divisor from D/2 to D (D limited to 2^DIVISOR_BITS - 1,
// divisor zero skipped) is tried with all 120 multiplier/add pairs. Each
// candidate goes through a product step, a start step, the divider and a
// compare step. The divider is the pacing unit. The result item sits
// in an output register, so the next request may be taken while it waits
// downstream. The limit register resets to 3 percent; the user must write
// it only while idle, as the block itself does not enforce this.
module fractional_baud_divider_search_top
    import fbd_pkg::*;
#(
    parameter int DIVISOR_BITS = DIVISOR_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [PCT_W-1:0] i_cfg_wr_data,   // max_error_percent
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [55:0]      s_axis_tdata,    // uart_clock_hz[26:0], baud_rate[48:27]
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [55:0]      m_axis_tdata,    // divisor[15:0], mul_value[19:16],
                                              // add_value[23:20], error_hz[55:24]
    output logic [0:0]       m_axis_tuser     // setting_ok[0]
);

    logic [PCT_W-1:0] r_max_err;
    t_div_req         div_req;
    t_div_rsp         div_rsp;
    t_result          result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_err <= MAX_ERR_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_err <= i_cfg_wr_data;
        end
    end

    fbd_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    fbd_search #(
        .DIVISOR_BITS (DIVISOR_BITS)
    ) u_search (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_clk_hz    (s_axis_tdata[CLK_W-1:0]),
        .i_baud      (s_axis_tdata[CLK_W+BAUD_W-1:CLK_W]),
        .i_max_err   (r_max_err),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_result    (result),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp)
    );

    assign m_axis_tdata = {result.error_hz, result.add_value, result.mul_value,
                           result.divisor};
    assign m_axis_tuser = result.setting_ok;

    // a result item only appears after the sequencer has left idle
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result item appeared without a search");

    // the divider is never started while still busy
    a_div_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider restarted while busy");

    // a passing setting always names a real candidate with add below mul
    a_ok_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |->
            (result.divisor != '0) && (result.error_hz != NO_ERR) &&
            (result.add_value < result.mul_value))
        else $error("accepted setting is inconsistent");

endmodule

[sim/fbd_search_checker.sv]
// ----------------------------------------------------------------------------
// fbd_search_checker
// Watches the request, result and limit-register channels of the fractional
// baud divider search block. It works out the best divisor, MulVal and
// DivAddVal for each accepted request and compares every result item,
// field by field, with the oldest pending prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbd_search_checker
    import fbd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [PCT_W-1:0] i_cfg_wr_data,
    input  logic             i_s_tvalid,
    input  logic             i_s_tready,
    input  logic [55:0]      i_s_tdata,      // uart_clock_hz[26:0], baud_rate[48:27]
    input  logic             i_m_tvalid,
    input  logic             i_m_tready,
    input  logic [55:0]      i_m_tdata,      // divisor[15:0], mul_value[19:16],
                                             // add_value[23:20], error_hz[55:24]
    input  logic [0:0]       i_m_tuser,      // setting_ok[0]
    output int               o_pending,
    output int               o_fail_count,
    output int               o_results,
    output int               o_rejects
);

    localparam int DIVISOR_BITS = DIVISOR_BITS_DEF;

    t_result          expected_settings[$];
    logic [PCT_W-1:0] err_limit = MAX_ERR_RESET;
    t_result          want;
    t_result          got;
    int               pending_cnt = 0;
    int               fail_count = 0;
    int               result_count = 0;
    int               reject_count = 0;

    assign o_pending    = pending_cnt;
    assign o_fail_count = fail_count;
    assign o_results    = result_count;
    assign o_rejects    = reject_count;

    // exhaustive search over divisor, multiplier and add value
    function automatic t_result search_best_setting(
        input logic [CLK_W-1:0]  clk_hz,
        input logic [BAUD_W-1:0] baud,
        input logic [PCT_W-1:0]  limit
    );
        longint unsigned clk64;
        longint unsigned baud64;
        longint unsigned nominal;
        longint unsigned d_max;
        longint unsigned dv;
        longint unsigned rate;
        longint unsigned err;
        longint unsigned best_err;
        int unsigned     m;
        int unsigned     a;
        bit              found;
        t_result         r;

        clk64        = clk_hz;
        baud64       = baud;
        d_max        = (64'd1 << DIVISOR_BITS) - 1;
        best_err     = NO_ERR;
        found        = 1'b0;
        r.divisor    = '0;
        r.mul_value  = MUL_FIRST;
        r.add_value  = '0;
        r.setting_ok = 1'b0;
        if (baud64 != 0) begin
            nominal = clk64 / ((64'd1 << RATE_SHIFT) * baud64);
            if (nominal > d_max) begin
                nominal = d_max;
            end
            for (dv = nominal / 2; dv <= nominal; dv++) begin
                // divisor zero is never a candidate
                if (dv == 0) begin
                    continue;
                end
                for (m = MUL_FIRST; m <= MUL_LAST; m++) begin
                    for (a = 0; a < m; a++) begin
                        rate = (clk64 * m) / ((64'd1 << RATE_SHIFT) * dv * (m + a));
                        err  = (baud64 > rate) ? baud64 - rate : rate - baud64;
                        // strict compare keeps the first best candidate
                        if (err < best_err) begin
                            best_err    = err;
                            r.divisor   = dv[DIV_OUT_W-1:0];
                            r.mul_value = m[MUL_W-1:0];
                            r.add_value = a[MUL_W-1:0];
                            found       = 1'b1;
                        end
                    end
                end
            end
            if (found) begin
                r.setting_ok = ((best_err * PCT_SCALE) / baud64) <= limit;
            end
        end
        r.error_hz = best_err[ERR_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string name, input longint unsigned exp_val,
                               input longint unsigned act_val);
        if (exp_val != act_val) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            err_limit = MAX_ERR_RESET;
        end else begin
            // retire the result first so a stray item never eats a fresh prediction
            if (i_m_tvalid && i_m_tready) begin
                got.divisor    = i_m_tdata[15:0];
                got.mul_value  = i_m_tdata[19:16];
                got.add_value  = i_m_tdata[23:20];
                got.error_hz   = i_m_tdata[55:24];
                got.setting_ok = i_m_tuser[0];
                if (expected_settings.size() == 0) begin
                    $error("result item with no request pending: divisor %0d", got.divisor);
                    fail_count++;
                end else begin
                    want = expected_settings.pop_front();
                    check_field("divisor", want.divisor, got.divisor);
                    check_field("mul_value", want.mul_value, got.mul_value);
                    check_field("add_value", want.add_value, got.add_value);
                    check_field("error_hz", want.error_hz, got.error_hz);
                    check_field("setting_ok", want.setting_ok, got.setting_ok);
                    result_count++;
                    if (!got.setting_ok) begin
                        reject_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_settings.push_back(
                    search_best_setting(i_s_tdata[26:0], i_s_tdata[48:27], err_limit));
            end
            if (i_cfg_wr_en) begin
                err_limit = i_cfg_wr_data;
            end
            pending_cnt = expected_settings.size();
        end
    end

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives baud setup requests into the fractional baud divider search block
// under random source gaps and sink stalls, changes the error limit between
// phases and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import fbd_pkg::*;

    localparam longint unsigned CLK_MAX  = 100_000_000;
    localparam longint unsigned BAUD_MAX = 4_000_000;
    localparam int              PHASES   = 5;
    localparam int              PHASE_ITEMS = 24;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_wr_en = 1'b0;
    logic [PCT_W-1:0] i_cfg_wr_data = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [55:0]      s_axis_tdata = '0;    // uart_clock_hz[26:0], baud_rate[48:27]
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [55:0]      m_axis_tdata;         // divisor[15:0], mul_value[19:16],
                                            // add_value[23:20], error_hz[55:24]
    logic [0:0]       m_axis_tuser;         // setting_ok[0]

    int pending;
    int fail_count;
    int result_count;
    int reject_count;
    int sent_count = 0;
    bit tx_calm = 1'b0;
    bit rd_calm = 1'b0;
    int rd_wait = 0;

    always #1 i_clk = ~i_clk;

    fractional_baud_divider_search_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    fbd_search_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_m_tuser     (m_axis_tuser),
        .o_pending     (pending),
        .o_fail_count  (fail_count),
        .o_results     (result_count),
        .o_rejects     (reject_count)
    );

    // sink: random stall after each result item, with calm stretches
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            if ($urandom_range(0, 15) == 0) begin
                rd_calm = !rd_calm;
            end
            rd_wait = rd_calm ? 0 : $urandom_range(0, 12);
            m_axis_tready <= (rd_wait == 0);
        end else if (rd_wait > 0) begin
            rd_wait--;
            m_axis_tready <= (rd_wait == 0);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_request(input logic [CLK_W-1:0] clk_hz, input logic [BAUD_W-1:0] baud);
        int gap;
        if ($urandom_range(0, 11) == 0) begin
            tx_calm = !tx_calm;
        end
        gap = tx_calm ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= {7'd0, baud, clk_hz};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent_count++;
    endtask

    // nominal divisor is kept small: the search tries every multiplier/add pair per divisor
    task automatic send_random();
        int              pick;
        int              nom;
        int              shift;
        longint unsigned baud_hi;
        longint unsigned baud;
        longint unsigned clk_lo;
        longint unsigned clk_hi;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            send_request(CLK_W'($urandom_range(1, CLK_MAX)), '0);
        end else begin
            if (pick < 25)      nom = 0;
            else if (pick < 60) nom = 1;
            else if (pick < 80) nom = 2;
            else if (pick < 92) nom = 3;
            else                nom = $urandom_range(4, 7);
            baud_hi = (nom == 0) ? BAUD_MAX : CLK_MAX / (16 * nom);
            if (baud_hi > BAUD_MAX) begin
                baud_hi = BAUD_MAX;
            end
            shift = $urandom_range(0, 1) ? 0 : $urandom_range(1, 21);
            baud_hi = baud_hi >> shift;
            if (baud_hi == 0) begin
                baud_hi = 1;
            end
            baud   = $urandom_range(1, baud_hi);
            clk_lo = (nom == 0) ? 1 : 16 * baud * nom;
            clk_hi = 16 * baud * (nom + 1) - 1;
            if (clk_hi > CLK_MAX) begin
                clk_hi = CLK_MAX;
            end
            send_request(CLK_W'($urandom_range(clk_lo, clk_hi)), BAUD_W'(baud));
        end
    endtask

    // drain all results, then leave the block alone a while before touching the limit
    task automatic settle_idle();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [PCT_W-1:0] pct);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= pct;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        logic [PCT_W-1:0] limit_val;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero baud, no nonzero divisor, exact fits, field extremes
        send_request(27'd1, 22'd0);
        send_request(27'd100_000_000, 22'd0);
        send_request(27'h555_5555, 22'd0);
        send_request(27'd1, 22'd4_000_000);
        send_request(27'd15, 22'd1);
        send_request(27'd7, 22'd2);
        send_request(27'd16, 22'd1);
        send_request(27'd31, 22'd1);
        send_request(27'd48, 22'd3);
        send_request(27'd64_000_000, 22'd4_000_000);
        send_request(27'd100_000_000, 22'd4_000_000);
        send_request(27'd100_000_000, 22'd3_125_000);
        send_request(27'd100_000_000, 22'd2_000_000);
        send_request(27'd99_999_999, 22'd1_562_500);
        send_request(27'd100_000_000, 22'd833_334);
        send_request(27'h3FF_FFFF, 22'h2A_AAAA);
        send_request(27'd95_000_000, 22'h15_5555);
        send_request(27'd1_843_200, 22'd115_200);
        send_request(27'd11_059_200, 22'd115_200);

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       limit_val = '0;
                1:       limit_val = '1;
                2:       limit_val = PCT_SCALE;
                3:       limit_val = PCT_W'($urandom_range(0, PCT_SCALE));
                default: limit_val = PCT_W'($urandom_range(1, 10));
            endcase
            settle_idle();
            write_limit(limit_val);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_random();
            end
        end

        settle_idle();
        $display("%0d baud requests sent, %0d results checked, %0d over the error limit",
                 sent_count, result_count, reject_count);
        $display("limits: reset, zero, all ones, 100 and random; nominal divisors 0..7, zero baud");
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("timeout waiting for the block");
        $display("Test completed with failures");
        $finish;
    end

endmodule

[files.f]
rtl/fbd_pkg.sv
rtl/fbd_divider.sv
rtl/fbd_search.sv
rtl/fractional_baud_divider_search_top.sv
sim/fbd_search_checker.sv
sim/tb_top.sv
